@@ hw/rtl/brts_pkg.sv @@
package brts_pkg;

    // Operand width of the shared divider. Coordinates and tile sizes are 16 bits.
    localparam int DIV_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Width of the configuration address: three 32-bit registers at 0, 4 and 8.
    localparam int APB_ADDR_W = 4;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ hw/rtl/brts_div.sv @@
// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module brts_div
    import brts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     den_reg;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            den_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ hw/rtl/blit_rect_tile_splitter.sv @@
// Tile splitter for blits on a surface stored as a grid of tiles.
// A request item on the req channel carries a rectangle on the tiled surface
// and a partner rectangle. For each tile the rectangle touches, one item leaves
// on the rsp channel, row by row and left to right, with the last one flagged.
// Requests that cannot be split are echoed once, flagged unsupported, and an
// empty rectangle produces no item at all.
// A request is checked in the cycle after it is taken. A request rejected by
// the flag, sub-surface or size checks goes to the pass state and is presented
// once the output register is free. Otherwise five divisions run back to back
// on one shared bit-serial divider, each as a start step, 16 quotient bits and
// a done step. A count step and the load of the first tile into the output
// register follow, then one tile per cycle while the receiver keeps up.
// One request is handled at a time and req_ready is high only when the block is
// idle. req_ready may be high while the last result still waits in the output
// register.
// When rsp_ready is low the output register holds its item and the tile walk
// pauses. Reset returns the block to idle with no result pending and loads
// all three size registers with 2048.
module blit_rect_tile_splitter
    import brts_pkg::*;
#(
    parameter int MAX_TILES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [15:0]           sub_index,
    input  logic [15:0]           rect_left,
    input  logic [15:0]           rect_top,
    input  logic [15:0]           rect_right,
    input  logic [15:0]           rect_bottom,
    input  logic [15:0]           peer_left,
    input  logic [15:0]           peer_top,
    input  logic [15:0]           peer_right,
    input  logic [15:0]           peer_bottom,
    input  logic                  mirror_horizontal,
    input  logic                  mirror_vertical,
    input  logic                  rotate_flag,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [15:0]           tile_index,
    output logic [15:0]           clip_left,
    output logic [15:0]           clip_top,
    output logic [15:0]           clip_right,
    output logic [15:0]           clip_bottom,
    output logic [15:0]           out_peer_left,
    output logic [15:0]           out_peer_top,
    output logic [15:0]           out_peer_right,
    output logic [15:0]           out_peer_bottom,
    output logic                  unsupported,
    output logic                  last_piece
);

    // Tile counts up to MAX_TILES fit in CNT_W bits.
    localparam int CNT_W = $clog2(MAX_TILES + 1);

    localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_CHECK     = 7'b0000010,
        S_DIV_START = 7'b0000100,
        S_DIV_WAIT  = 7'b0001000,
        S_COUNT     = 7'b0010000,
        S_EMIT      = 7'b0100000,
        S_PASS      = 7'b1000000
    } state_t;

    // Order of the divisions run on the shared divider.
    typedef enum logic [4:0] {
        DS_C0  = 5'b00001,
        DS_C1  = 5'b00010,
        DS_R0  = 5'b00100,
        DS_R1  = 5'b01000,
        DS_TPR = 5'b10000
    } div_step_t;

    // Configuration registers.
    logic [15:0] tile_width_reg;
    logic [15:0] tile_height_reg;
    logic [15:0] image_width_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= 16'd2048;
            tile_height_reg <= 16'd2048;
            image_width_reg <= 16'd2048;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TILE_WIDTH:  tile_width_reg  <= pwdata[15:0];
                REG_TILE_HEIGHT: tile_height_reg <= pwdata[15:0];
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TILE_WIDTH:  prdata = {16'd0, tile_width_reg};
            REG_TILE_HEIGHT: prdata = {16'd0, tile_height_reg};
            REG_IMAGE_WIDTH: prdata = {16'd0, image_width_reg};
            default:         prdata = '0;
        endcase
    end

    // A tile size of zero behaves as a size of one.
    logic [15:0] tw_eff;
    logic [15:0] th_eff;

    assign tw_eff = (tile_width_reg == '0) ? 16'd1 : tile_width_reg;
    assign th_eff = (tile_height_reg == '0) ? 16'd1 : tile_height_reg;

    // Control state.
    state_t    state_reg, state_next;
    div_step_t step_reg, step_next;
    logic      rsp_valid_reg, rsp_valid_next;

    // Captured request.
    logic [15:0] sub_reg;
    logic [15:0] rl_reg, rt_reg, rr_reg, rb_reg;
    logic [15:0] pl_reg, pt_reg, pr_reg, pb_reg;
    logic        flag_reg;

    // Tile range, tiles per row and walk position.
    logic [15:0] c0_reg, c1_reg, r0_reg, r1_reg;
    logic [15:0] tpr_reg;
    logic [15:0] col_reg, row_reg;
    logic [15:0] base_reg;
    logic [16:0] ox0_reg, ox_reg, oy_reg;

    // Output register.
    logic [15:0] idx_out_reg;
    logic [15:0] cl_out_reg, ct_out_reg, cr_out_reg, cb_out_reg;
    logic [15:0] pl_out_reg, pt_out_reg, pr_out_reg, pb_out_reg;
    logic        uns_out_reg, last_out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    brts_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Operand selection for the divider.
    always_comb
    begin
        div_req.start = (state_reg == S_DIV_START);
        case (step_reg)
            DS_C0:
            begin
                div_req.dividend = rl_reg;
                div_req.divisor  = tw_eff;
            end
            DS_C1:
            begin
                div_req.dividend = rr_reg - 16'd1;
                div_req.divisor  = tw_eff;
            end
            DS_R0:
            begin
                div_req.dividend = rt_reg;
                div_req.divisor  = th_eff;
            end
            DS_R1:
            begin
                div_req.dividend = rb_reg - 16'd1;
                div_req.divisor  = th_eff;
            end
            DS_TPR:
            begin
                div_req.dividend = image_width_reg;
                div_req.divisor  = tw_eff;
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = tw_eff;
            end
        endcase
    end

    // Request checks. The rectangle sizes are compared as 17-bit differences,
    // which keeps a reversed partner rectangle distinct from any real width.
    logic empty_rect;
    logic quick_reject;
    logic size_mismatch;

    assign empty_rect    = (rl_reg >= rr_reg) || (rt_reg >= rb_reg);
    assign size_mismatch = (({1'b0, rr_reg} - {1'b0, rl_reg}) != ({1'b0, pr_reg} - {1'b0, pl_reg}))
                        || (({1'b0, rb_reg} - {1'b0, rt_reg}) != ({1'b0, pb_reg} - {1'b0, pt_reg}));
    assign quick_reject  = (sub_reg != '0) || size_mismatch || flag_reg;

    // Tile count check. Each side is tested alone first so the product
    // needs only CNT_W bits per factor.
    logic [16:0]        ncols, nrows;
    logic [2*CNT_W-1:0] ncount;
    logic               too_many;
    logic [31:0]        base_full;

    always_comb
    begin
        ncols     = {1'b0, c1_reg} - {1'b0, c0_reg} + 17'd1;
        nrows     = {1'b0, r1_reg} - {1'b0, r0_reg} + 17'd1;
        ncount    = ncols[CNT_W-1:0] * nrows[CNT_W-1:0];
        too_many  = (ncols > 17'(MAX_TILES)) || (nrows > 17'(MAX_TILES))
                 || (ncount > (2*CNT_W)'(MAX_TILES));
        base_full = r0_reg * tpr_reg;
    end

    // Clip of the rectangle against the current tile.
    logic [16:0] rl17, rt17, rr17, rb17;
    logic [16:0] ox_end, oy_end;
    logic [16:0] x0, x1, y0, y1;
    logic [16:0] cl_d, ct_d, cr_d, cb_d;
    logic        last_col, last_row;

    always_comb
    begin
        rl17     = {1'b0, rl_reg};
        rt17     = {1'b0, rt_reg};
        rr17     = {1'b0, rr_reg};
        rb17     = {1'b0, rb_reg};
        ox_end   = ox_reg + {1'b0, tw_eff};
        oy_end   = oy_reg + {1'b0, th_eff};
        x0       = (rl17 > ox_reg) ? rl17 : ox_reg;
        y0       = (rt17 > oy_reg) ? rt17 : oy_reg;
        x1       = (rr17 < ox_end) ? rr17 : ox_end;
        y1       = (rb17 < oy_end) ? rb17 : oy_end;
        cl_d     = x0 - ox_reg;
        ct_d     = y0 - oy_reg;
        cr_d     = x1 - ox_reg;
        cb_d     = y1 - oy_reg;
        last_col = (col_reg == c1_reg);
        last_row = (row_reg == r1_reg);
    end

    logic out_free;
    logic out_load;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_PASS));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;

        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = DS_C0;
                if (empty_rect)
                begin
                    state_next = S_IDLE;
                end
                else if (quick_reject)
                begin
                    state_next = S_PASS;
                end
                else
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (step_reg)
                        DS_C0:   step_next = DS_C1;
                        DS_C1:   step_next = DS_R0;
                        DS_R0:   step_next = DS_R1;
                        DS_R1:   step_next = DS_TPR;
                        default: step_next = DS_C0;
                    endcase
                    state_next = (step_reg == DS_TPR) ? S_COUNT : S_DIV_START;
                end
            end
            S_COUNT:
            begin
                state_next = too_many ? S_PASS : S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load && last_col && last_row)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PASS:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= DS_C0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            sub_reg  <= sub_index;
            rl_reg   <= rect_left;
            rt_reg   <= rect_top;
            rr_reg   <= rect_right;
            rb_reg   <= rect_bottom;
            pl_reg   <= peer_left;
            pt_reg   <= peer_top;
            pr_reg   <= peer_right;
            pb_reg   <= peer_bottom;
            flag_reg <= mirror_horizontal || mirror_vertical || rotate_flag;
        end

        // The first tile origin is the dividend minus its remainder.
        if ((state_reg == S_DIV_WAIT) && div_rsp.done)
        begin
            case (step_reg)
                DS_C0:
                begin
                    c0_reg  <= div_rsp.quot;
                    ox0_reg <= {1'b0, rl_reg - div_rsp.rem};
                end
                DS_C1:
                begin
                    c1_reg <= div_rsp.quot;
                end
                DS_R0:
                begin
                    r0_reg <= div_rsp.quot;
                    oy_reg <= {1'b0, rt_reg - div_rsp.rem};
                end
                DS_R1:
                begin
                    r1_reg <= div_rsp.quot;
                end
                DS_TPR:
                begin
                    tpr_reg <= div_rsp.quot + {15'd0, (div_rsp.rem != '0)};
                end
                default: ;
            endcase
        end

        if (state_reg == S_COUNT)
        begin
            col_reg  <= c0_reg;
            row_reg  <= r0_reg;
            ox_reg   <= ox0_reg;
            base_reg <= base_full[15:0];
        end

        // Walk to the next tile once the current one is in the output register.
        if ((state_reg == S_EMIT) && out_load)
        begin
            if (last_col)
            begin
                col_reg  <= c0_reg;
                ox_reg   <= ox0_reg;
                row_reg  <= row_reg + 16'd1;
                oy_reg   <= oy_end;
                base_reg <= base_reg + tpr_reg;
            end
            else
            begin
                col_reg <= col_reg + 16'd1;
                ox_reg  <= ox_end;
            end
        end

        if (out_load)
        begin
            if (state_reg == S_PASS)
            begin
                idx_out_reg  <= sub_reg;
                cl_out_reg   <= rl_reg;
                ct_out_reg   <= rt_reg;
                cr_out_reg   <= rr_reg;
                cb_out_reg   <= rb_reg;
                pl_out_reg   <= pl_reg;
                pt_out_reg   <= pt_reg;
                pr_out_reg   <= pr_reg;
                pb_out_reg   <= pb_reg;
                uns_out_reg  <= 1'b1;
                last_out_reg <= 1'b1;
            end
            else
            begin
                idx_out_reg  <= base_reg + col_reg;
                cl_out_reg   <= cl_d[15:0];
                ct_out_reg   <= ct_d[15:0];
                cr_out_reg   <= cr_d[15:0];
                cb_out_reg   <= cb_d[15:0];
                pl_out_reg   <= pl_reg + (x0[15:0] - rl_reg);
                pt_out_reg   <= pt_reg + (y0[15:0] - rt_reg);
                pr_out_reg   <= pl_reg + (x1[15:0] - rl_reg);
                pb_out_reg   <= pt_reg + (y1[15:0] - rt_reg);
                uns_out_reg  <= 1'b0;
                last_out_reg <= last_col && last_row;
            end
        end
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign tile_index      = idx_out_reg;
    assign clip_left       = cl_out_reg;
    assign clip_top        = ct_out_reg;
    assign clip_right      = cr_out_reg;
    assign clip_bottom     = cb_out_reg;
    assign out_peer_left   = pl_out_reg;
    assign out_peer_top    = pt_out_reg;
    assign out_peer_right  = pr_out_reg;
    assign out_peer_bottom = pb_out_reg;
    assign unsupported     = uns_out_reg;
    assign last_piece      = last_out_reg;

endmodule
